[design/central_difference_gradient_magnitude_unit_defines.svh]
// assertion macros for the gradient magnitude unit checker
`ifndef CENTRAL_DIFFERENCE_GRADIENT_MAGNITUDE_UNIT_DEFINES_SVH
`define CENTRAL_DIFFERENCE_GRADIENT_MAGNITUDE_UNIT_DEFINES_SVH

// checked only out of reset
`define CDGM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CDGM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/cdgm_pkg.sv]
// shared types and constants of the gradient magnitude unit
package cdgm_pkg;

  localparam int DefMaxWidth = 2048;
  localparam int ColW        = 14;
  localparam int RowW        = 16;
  localparam int PixW        = 8;
  localparam int GradW       = 9;
  localparam int MagW        = 16;
  localparam int OutColW     = 11;
  localparam int CfgWidthW   = 12;
  localparam int CfgDataW    = 16;
  localparam int CfgIdxW     = 2;
  localparam int OutDataW    = 64;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  localparam logic [CfgWidthW-1:0] ResetWidth  = 12'd640;
  localparam logic [RowW-1:0]      ResetHeight = 16'd480;

  // classified pixel handed from the front to the back
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            first_col;
    logic            last_col;
    logic            first_row;
    logic            last_row;
  } cdgm_item_t;

endpackage

[design/central_difference_gradient_magnitude_unit.sv]
// path: a pixel passes the queue, the line store read and update, the iterative square root
// and the result register; the back takes no new pixel until all results of its current one are out
// rate is set by the one-bit-per-cycle root unit; the two-entry queue lets input run ahead
// reset: asynchronous active low, clears position, registers and result valid;
// line stores are not cleared, row 0 of each frame writes them
module central_difference_gradient_magnitude_unit #(
  parameter int MaxWidth = cdgm_pkg::DefMaxWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cdgm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cdgm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [8:0] grad_x, [17:9] grad_y, [33:18] magnitude, [44:34] out_col, [60:45] out_row
  output logic [cdgm_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser   // [0] frame_done
);
  import cdgm_pkg::*;

  logic       push, pop, full, empty;
  cdgm_item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;

  cdgm_front #(.MaxWidth(MaxWidth)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pix_valid_i(s_axis_tvalid),
    .pix_i      (s_axis_tdata),
    .pix_ready_o(s_axis_tready),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  cdgm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (full),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .empty_o    (empty)
  );

  cdgm_back #(.MaxWidth(MaxWidth)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .item_i   (pop_item),
    .pop_o    (pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_last_o (m_axis_tlast),
    .m_done_o (m_axis_tuser)
  );

endmodule

[design/cdgm_ram.sv]
// generic single write, single read memory with registered read data
module cdgm_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/cdgm_queue.sv]
// two-entry queue of classified pixels between front and back
module cdgm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cdgm_pkg::cdgm_item_t push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output cdgm_pkg::cdgm_item_t pop_item_o,
  output logic                empty_o
);
  import cdgm_pkg::*;

  cdgm_item_t  mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_item_o = mem_q[rptr_q];

endmodule

[design/cdgm_front.sv]
// input side: configuration registers, frame position and classification
module cdgm_front #(
  parameter int MaxWidth = cdgm_pkg::DefMaxWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [cdgm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cdgm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          pix_valid_i,
  input  logic [cdgm_pkg::PixW-1:0]     pix_i,
  output logic                          pix_ready_o,
  output logic                          push_o,
  output cdgm_pkg::cdgm_item_t          item_o,
  input  logic                          full_i
);
  import cdgm_pkg::*;

  logic [CfgWidthW-1:0] width_q;
  logic [RowW-1:0]      height_q;
  logic [ColW-1:0]      col_q;
  logic [RowW-1:0]      row_q;
  logic [RowW-1:0]      width_eff;
  logic [RowW:0]        height_eff;
  logic                 last_col, last_row, accept, cfg_hit;

  always_comb begin
    width_eff = {{(RowW-CfgWidthW){1'b0}}, width_q};
    if (width_q == '0) begin
      width_eff = RowW'(1);
    end else if (width_eff > RowW'(MaxWidth)) begin
      width_eff = RowW'(MaxWidth);
    end
    height_eff = (height_q == '0) ? (RowW+1)'(1) : {1'b0, height_q};
  end

  assign last_col = (RowW'(col_q) + RowW'(1)) >= width_eff;
  assign last_row = ({1'b0, row_q} + (RowW+1)'(1)) >= height_eff;
  assign accept   = pix_valid_i && !full_i;
  assign cfg_hit  = cfg_valid_i &&
                    ((cfg_index_i == RegFrameWidth) || (cfg_index_i == RegFrameHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == RegFrameWidth) begin
        width_q <= cfg_data_i[CfgWidthW-1:0];
      end else begin
        height_q <= cfg_data_i;
      end
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  assign pix_ready_o = !full_i;
  assign push_o      = accept;

  always_comb begin
    item_o.pixel     = pix_i;
    item_o.col       = col_q;
    item_o.row       = row_q;
    item_o.first_col = (col_q == '0);
    item_o.last_col  = last_col;
    item_o.first_row = (row_q == '0);
    item_o.last_row  = last_row;
  end

endmodule

[design/cdgm_back.sv]
// work side: line stores, difference terms, iterative root, result register
module cdgm_back #(
  parameter int MaxWidth = cdgm_pkg::DefMaxWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  cdgm_pkg::cdgm_item_t           item_i,
  output logic                           pop_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [cdgm_pkg::OutDataW-1:0]  m_data_o,
  output logic                           m_last_o,
  output logic                           m_done_o
);
  import cdgm_pkg::*;

  localparam int AddrW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;

  typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_SEL, S_ROOT, S_OUT} state_e;

  state_e          state_q;
  cdgm_item_t      it_q;
  logic [PixW-1:0] mid_q, up_q;
  logic [PixW-1:0] recent0_q, recent1_q, prev2_q;

  logic [2:0]              rvld_q;
  logic signed [GradW-1:0] rgx_q [3];
  logic signed [GradW-1:0] rgy_q [3];
  logic [OutColW-1:0]      rcol_q [3];
  logic [RowW-1:0]         rrow_q [3];
  logic [2:0]              rdone_q;

  logic signed [GradW-1:0] cgx_q, cgy_q;
  logic [OutColW-1:0]      ccol_q;
  logic [RowW-1:0]         crow_q;
  logic                    cdone_q;
  logic [31:0]             v_q, res_q, bit_q;
  logic [3:0]              iter_q;

  logic                    mvalid_q, mlast_q, mdone_q;
  logic [OutDataW-1:0]     mdata_q;

  // memory ports
  logic [AddrW-1:0] raddr_new, raddr_old, waddr;
  logic [PixW-1:0]  rdata_new, rdata_old, wdata_old;
  logic             we;

  always_comb begin
    raddr_old = item_i.col[AddrW-1:0];
    raddr_new = item_i.col[AddrW-1:0];
    if (state_q == S_RD1) begin
      raddr_new = it_q.last_col ? it_q.col[AddrW-1:0]
                                : it_q.col[AddrW-1:0] + AddrW'(1);
    end
  end

  assign we        = (state_q == S_RD2);
  assign waddr     = it_q.col[AddrW-1:0];
  assign wdata_old = it_q.first_row ? it_q.pixel : mid_q;

  cdgm_ram #(.Width(PixW), .Depth(MaxWidth)) u_line_newer (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(it_q.pixel),
    .raddr_i(raddr_new),
    .rdata_o(rdata_new)
  );

  cdgm_ram #(.Width(PixW), .Depth(MaxWidth)) u_line_older (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata_old),
    .raddr_i(raddr_old),
    .rdata_o(rdata_old)
  );

  function automatic logic signed [GradW-1:0] diff(input logic [PixW-1:0] a,
                                                    input logic [PixW-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // operands of the three possible results of one pixel
  logic [PixW-1:0] right, left0, left1, up1, left2, up2;
  logic [RowW-1:0] row_up;
  logic [ColW-1:0] col_left;

  always_comb begin
    right    = it_q.last_col ? mid_q : rdata_new;
    left0    = it_q.first_col ? mid_q : recent0_q;
    left1    = (it_q.col == ColW'(1)) ? recent1_q : prev2_q;
    up1      = it_q.first_row ? recent1_q : recent0_q;
    left2    = it_q.first_col ? it_q.pixel : recent1_q;
    up2      = it_q.first_row ? it_q.pixel : mid_q;
    row_up   = it_q.row - RowW'(1);
    col_left = it_q.col - ColW'(1);
  end

  // next pending result, lowest slot first
  logic [1:0] sel;
  always_comb begin
    sel = 2'd2;
    if (rvld_q[0]) begin
      sel = 2'd0;
    end else if (rvld_q[1]) begin
      sel = 2'd1;
    end
  end

  logic [31:0] trial;
  logic [17:0] sum;
  logic signed [2*GradW-1:0] gx_ext, gy_ext, gx_sq, gy_sq;
  assign gx_ext = (2*GradW)'(rgx_q[sel]);
  assign gy_ext = (2*GradW)'(rgy_q[sel]);
  assign gx_sq  = gx_ext * gx_ext;
  assign gy_sq  = gy_ext * gy_ext;
  assign trial  = res_q + bit_q;
  assign sum    = $unsigned(gx_sq) + $unsigned(gy_sq);

  logic [MagW-1:0] mag;
  assign mag = res_q[MagW-1:0] + MagW'(128);

  logic out_load;
  assign out_load = (state_q == S_OUT) && (!mvalid_q || m_ready_i);

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rvld_q    <= '0;
      recent0_q <= '0;
      recent1_q <= '0;
      prev2_q   <= '0;
      mvalid_q  <= 1'b0;
      iter_q    <= '0;
    end else begin
      if (out_load) begin
        mvalid_q <= 1'b1;
      end else if (mvalid_q && m_ready_i) begin
        mvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            it_q    <= item_i;
            state_q <= S_RD1;
          end
        end
        S_RD1: begin
          mid_q   <= rdata_new;
          up_q    <= rdata_old;
          state_q <= S_RD2;
        end
        S_RD2: begin
          rvld_q[0]  <= !it_q.first_row;
          rgx_q[0]   <= diff(right, left0);
          rgy_q[0]   <= diff(it_q.pixel, up_q);
          rcol_q[0]  <= OutColW'(it_q.col);
          rrow_q[0]  <= row_up;
          rdone_q[0] <= 1'b0;
          rvld_q[1]  <= it_q.last_row && !it_q.first_col;
          rgx_q[1]   <= diff(it_q.pixel, left1);
          rgy_q[1]   <= diff(recent1_q, up1);
          rcol_q[1]  <= OutColW'(col_left);
          rrow_q[1]  <= it_q.row;
          rdone_q[1] <= 1'b0;
          rvld_q[2]  <= it_q.last_row && it_q.last_col;
          rgx_q[2]   <= diff(it_q.pixel, left2);
          rgy_q[2]   <= diff(it_q.pixel, up2);
          rcol_q[2]  <= OutColW'(it_q.col);
          rrow_q[2]  <= it_q.row;
          rdone_q[2] <= 1'b1;
          if (!it_q.first_row) begin
            recent0_q <= mid_q;
          end
          recent1_q <= it_q.pixel;
          prev2_q   <= recent1_q;
          state_q   <= S_SEL;
        end
        S_SEL: begin
          if (rvld_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            rvld_q[sel] <= 1'b0;
            cgx_q       <= rgx_q[sel];
            cgy_q       <= rgy_q[sel];
            ccol_q      <= rcol_q[sel];
            crow_q      <= rrow_q[sel];
            cdone_q     <= rdone_q[sel];
            v_q         <= {sum, 14'd0};
            res_q       <= '0;
            bit_q       <= 32'h4000_0000;
            iter_q      <= '0;
            state_q     <= S_ROOT;
          end
        end
        S_ROOT: begin
          // one result bit per cycle, 16 steps
          if (v_q >= trial) begin
            v_q   <= v_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q  <= bit_q >> 2;
          iter_q <= iter_q + 4'd1;
          if (iter_q == 4'd15) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            mdata_q  <= {3'b000, crow_q, ccol_q, mag, cgy_q, cgx_q};
            mlast_q  <= (rvld_q == '0);
            mdone_q  <= cdone_q;
            state_q  <= S_SEL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_valid_o = mvalid_q;
  assign m_data_o  = mdata_q;
  assign m_last_o  = mlast_q;
  assign m_done_o  = mdone_q;

endmodule

[design/cdgm_checker.sv]
// port-level checker for the gradient magnitude unit, bound to the top level
`include "central_difference_gradient_magnitude_unit_defines.svh"

module cdgm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // a stalled result transaction keeps its payload
  `CDGM_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "payload changed while stalled")
  // the frame's final result is always the last one of its pixel
  `CDGM_ASSERT(a_done_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "frame end without tlast")
  // magnitude carries the +1 offset
  `CDGM_ASSERT(a_mag_min, m_axis_tvalid |-> m_axis_tdata[33:18] >= 16'd128, "magnitude below one")
  // nothing leaves once reset has been seen at an edge
  `CDGM_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

endmodule

bind central_difference_gradient_magnitude_unit cdgm_checker u_cdgm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
